### rtl/core/fsp_pkg.sv
// fsp_pkg: shared types and constants of the serial command frame parser
package fsp_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned WORD_W  = 16;
	localparam int unsigned EV_W    = 3;
	localparam int unsigned IDX_W   = 6;
	localparam int unsigned LEN_W   = 6;
	localparam int unsigned CFG_IDX_W = 2;

	localparam logic [EV_W-1:0] EV_START    = 3'd0;
	localparam logic [EV_W-1:0] EV_LAUNCH   = 3'd1;
	localparam logic [EV_W-1:0] EV_DATA     = 3'd2;
	localparam logic [EV_W-1:0] EV_MISMATCH = 3'd3;
	localparam logic [EV_W-1:0] EV_JUMP     = 3'd4;

	localparam logic [WORD_W-1:0] CMD_START  = 16'h5840;
	localparam logic [WORD_W-1:0] CMD_LAUNCH = 16'h5210;
	localparam logic [WORD_W-1:0] CMD_DATA   = 16'h5051;
	localparam logic [WORD_W-1:0] CMD_JUMP   = 16'h2525;

	localparam logic [CFG_IDX_W-1:0] REG_HEADER   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TAIL     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_NODE     = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_EXPECTED = 2'd3;

	localparam logic [BYTE_W-1:0] HEADER_RST   = 8'h55;
	localparam logic [BYTE_W-1:0] TAIL_RST     = 8'hAA;
	localparam logic [BYTE_W-1:0] NODE_RST     = 8'h24;
	localparam logic [WORD_W-1:0] EXPECTED_RST = 16'h0000;

	localparam int unsigned MIN_LEN      = 3;
	localparam int unsigned TRAILER_LEN  = 4;
	localparam int unsigned POS_ADDR     = 2;
	localparam int unsigned POS_CMD_HI   = 3;
	localparam int unsigned POS_CMD_LO   = 4;
	localparam int unsigned POS_NUM_HI   = 5;
	localparam int unsigned POS_NUM_LO   = 6;
	localparam int unsigned POS_PLEN     = 7;
	localparam int unsigned PAYLOAD_BASE = 8;
	localparam int unsigned PAYLOAD_OVH  = 6;

	typedef enum logic [1:0] {
		PH_HUNT = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} parse_phase_t;

	typedef enum logic [1:0] {
		EM_IDLE   = 2'd0,
		EM_SINGLE = 2'd1,
		EM_READ   = 2'd2,
		EM_LOAD   = 2'd3
	} emit_state_t;

	typedef struct packed {
		logic              start;
		logic [WORD_W-1:0] cmd;
		logic [WORD_W-1:0] num;
		logic [BYTE_W-1:0] plen;
		logic [LEN_W-1:0]  flen;
	} frame_cmd_t;

endpackage

### rtl/core/fsp_frame_mem.sv
// fsp_frame_mem: frame byte store, one write port and one registered read port
module fsp_frame_mem
	import fsp_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [BYTE_W-1:0] wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [BYTE_W-1:0] rdata
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/fsp_rx_parser.sv
// fsp_rx_parser: header hunt, length check, frame collection and checksum
module fsp_rx_parser
	import fsp_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [BYTE_W-1:0] rx_byte,
	input  logic [BYTE_W-1:0] header_byte,
	input  logic [BYTE_W-1:0] tail_byte,
	input  logic [BYTE_W-1:0] node_address,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output logic [BYTE_W-1:0] mem_wdata,
	output frame_cmd_t        frame_cmd
);

	parse_phase_t      phase_q;
	parse_phase_t      phase_d;
	logic [AW-1:0]     count_q;
	logic [AW-1:0]     len_q;
	logic [BYTE_W-1:0] xor_q;
	logic [BYTE_W-1:0] addr_q;
	logic [WORD_W-1:0] cmd_q;
	logic [WORD_W-1:0] num_q;
	logic [BYTE_W-1:0] plen_q;

	logic len_bad;
	logic at_tail;
	logic in_body;

	assign len_bad = (rx_byte < BYTE_W'(MIN_LEN)) ||
		(({1'b0, rx_byte} + 9'(TRAILER_LEN)) > 9'(DEPTH));
	assign in_body = (phase_q == PH_BODY);
	assign at_tail = (count_q == (len_q + AW'(3)));

	assign mem_we    = accept && in_body && !at_tail;
	assign mem_waddr = count_q;
	assign mem_wdata = rx_byte;

	always_comb begin
		frame_cmd.start = accept && in_body && at_tail && (xor_q == '0) &&
			(rx_byte == tail_byte) && (addr_q == node_address);
		frame_cmd.cmd   = cmd_q;
		frame_cmd.num   = num_q;
		frame_cmd.plen  = plen_q;
		frame_cmd.flen  = LEN_W'(len_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		if (accept) begin
			case (phase_q)
				PH_LEN: begin
					phase_d = len_bad ? PH_HUNT : PH_BODY;
				end
				PH_BODY: begin
					if (at_tail) begin
						phase_d = PH_HUNT;
					end
				end
				default: begin
					phase_d = (rx_byte == header_byte) ? PH_LEN : PH_HUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			len_q   <= '0;
			xor_q   <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_LEN: begin
					if (!len_bad) begin
						len_q   <= AW'(rx_byte);
						xor_q   <= rx_byte;
						count_q <= AW'(2);
					end
				end
				PH_BODY: begin
					if (at_tail) begin
						count_q <= '0;
					end else begin
						xor_q   <= xor_q ^ rx_byte;
						count_q <= count_q + AW'(1);
					end
				end
				default: begin
					if (rx_byte == header_byte) begin
						count_q <= AW'(1);
						xor_q   <= '0;
					end
				end
			endcase
		end
	end

	// header fields of the current frame, zero past the body
	always_ff @(posedge clk) begin
		if (accept && (phase_q == PH_LEN) && !len_bad) begin
			addr_q <= '0;
			cmd_q  <= '0;
			num_q  <= '0;
			plen_q <= '0;
		end else if (mem_we && (count_q <= (len_q + AW'(1)))) begin
			case (count_q)
				AW'(POS_ADDR):   addr_q       <= rx_byte;
				AW'(POS_CMD_HI): cmd_q[15:8]  <= rx_byte;
				AW'(POS_CMD_LO): cmd_q[7:0]   <= rx_byte;
				AW'(POS_NUM_HI): num_q[15:8]  <= rx_byte;
				AW'(POS_NUM_LO): num_q[7:0]   <= rx_byte;
				AW'(POS_PLEN):   plen_q       <= rx_byte;
				default: ;
			endcase
		end
	end

endmodule

### rtl/core/fsp_emitter.sv
// fsp_emitter: command decode, payload read-out and output register
module fsp_emitter
	import fsp_pkg::*;
#(
	parameter int unsigned DEPTH = 64,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  frame_cmd_t        frame_cmd,
	input  logic [WORD_W-1:0] expected_packet,
	output logic              busy,
	output logic              mem_re,
	output logic [AW-1:0]     mem_raddr,
	input  logic [BYTE_W-1:0] mem_rdata,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [EV_W-1:0]   event_res,
	output logic [WORD_W-1:0] value,
	output logic [BYTE_W-1:0] data_byte,
	output logic              data_valid,
	output logic [IDX_W-1:0]  byte_index,
	output logic              last
);

	emit_state_t       state_q;
	emit_state_t       state_d;
	logic [EV_W-1:0]   ev_q;
	logic [WORD_W-1:0] val_q;
	logic [IDX_W-1:0]  cnt_q;
	logic [IDX_W-1:0]  k_q;

	logic              out_valid_q;
	logic [EV_W-1:0]   out_ev_q;
	logic [WORD_W-1:0] out_val_q;
	logic [BYTE_W-1:0] out_data_q;
	logic              out_dv_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic              out_last_q;

	logic slot_free;
	logic load_single;
	logic load_data;
	logic final_byte;
	logic num_bad;
	logic plen_bad;
	logic cmd_known;

	assign slot_free  = !out_valid_q || !out_stall;
	assign final_byte = ((k_q + IDX_W'(1)) == cnt_q);
	assign num_bad    = (frame_cmd.num != expected_packet);
	assign plen_bad   = (({1'b0, frame_cmd.plen} + 9'(PAYLOAD_OVH)) > 9'(frame_cmd.flen));
	assign cmd_known  = (frame_cmd.cmd == CMD_START) || (frame_cmd.cmd == CMD_LAUNCH) ||
		(frame_cmd.cmd == CMD_DATA) || (frame_cmd.cmd == CMD_JUMP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		mem_re      = 1'b0;
		load_single = 1'b0;
		load_data   = 1'b0;
		case (state_q)
			EM_IDLE: begin
				if (frame_cmd.start && cmd_known) begin
					if ((frame_cmd.cmd == CMD_DATA) && !num_bad && !plen_bad &&
						(frame_cmd.plen != '0)) begin
						state_d = EM_READ;
					end else begin
						state_d = EM_SINGLE;
					end
				end
			end
			EM_SINGLE: begin
				if (slot_free) begin
					load_single = 1'b1;
					state_d     = EM_IDLE;
				end
			end
			EM_READ: begin
				mem_re  = 1'b1;
				state_d = EM_LOAD;
			end
			EM_LOAD: begin
				if (slot_free) begin
					load_data = 1'b1;
					state_d   = final_byte ? EM_IDLE : EM_READ;
				end
			end
			default: state_d = EM_IDLE;
		endcase
	end

	assign busy      = (state_q != EM_IDLE);
	assign mem_raddr = AW'(PAYLOAD_BASE) + AW'(k_q);

	// result kind latched at frame end
	always_ff @(posedge clk) begin
		if ((state_q == EM_IDLE) && frame_cmd.start) begin
			k_q   <= '0;
			cnt_q <= IDX_W'(frame_cmd.plen);
			case (frame_cmd.cmd)
				CMD_START: begin
					ev_q  <= EV_START;
					val_q <= frame_cmd.num;
				end
				CMD_LAUNCH: begin
					ev_q  <= EV_LAUNCH;
					val_q <= '0;
				end
				CMD_DATA: begin
					ev_q  <= (num_bad || plen_bad) ? EV_MISMATCH : EV_DATA;
					val_q <= frame_cmd.num;
				end
				default: begin
					ev_q  <= EV_JUMP;
					val_q <= '0;
				end
			endcase
		end else if (load_data) begin
			k_q <= k_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_single || load_data) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_single) begin
			out_ev_q   <= ev_q;
			out_val_q  <= val_q;
			out_data_q <= '0;
			out_dv_q   <= 1'b0;
			out_idx_q  <= '0;
			out_last_q <= 1'b1;
		end else if (load_data) begin
			out_ev_q   <= EV_DATA;
			out_val_q  <= val_q;
			out_data_q <= mem_rdata;
			out_dv_q   <= 1'b1;
			out_idx_q  <= k_q;
			out_last_q <= final_byte;
		end
	end

	assign out_valid  = out_valid_q;
	assign event_res  = out_ev_q;
	assign value      = out_val_q;
	assign data_byte  = out_data_q;
	assign data_valid = out_dv_q;
	assign byte_index = out_idx_q;
	assign last       = out_last_q;

endmodule

### rtl/core/serial_command_frame_parser_core.sv
// serial_command_frame_parser_core: top level of the serial command frame parser
//
//   channel  dir  handshake           payload
//   in       in   in_valid/in_stall   rx_byte
//   out      out  out_valid/out_stall event_res value data_byte data_valid byte_index last
//   cfg      in   cfg_we              cfg_index cfg_data
//
// one received byte is taken per cycle while a frame is being collected
// at frame end of a known command the input stalls while a single result, or
// the P payload bytes of a data packet read in turn via the store's one read port,
// are loaded, and longer while a held result blocks the output register
// the output register lets the parser keep taking bytes while a result waits
// reset clears parse state, emitter state, out_valid and the config registers; the frame store is not cleared
module serial_command_frame_parser_core
	import fsp_pkg::*;
#(
	parameter int unsigned FRAME_DEPTH = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    rx_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [EV_W-1:0]      event_res,
	output logic [WORD_W-1:0]    value,
	output logic [BYTE_W-1:0]    data_byte,
	output logic                 data_valid,
	output logic [IDX_W-1:0]     byte_index,
	output logic                 last,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	localparam int unsigned AW = $clog2(FRAME_DEPTH);

	logic [BYTE_W-1:0] header_q;
	logic [BYTE_W-1:0] tail_q;
	logic [BYTE_W-1:0] node_q;
	logic [WORD_W-1:0] expected_q;

	logic              in_accept;
	logic              busy;
	frame_cmd_t        frame_cmd;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [BYTE_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_q   <= HEADER_RST;
			tail_q     <= TAIL_RST;
			node_q     <= NODE_RST;
			expected_q <= EXPECTED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HEADER:   header_q   <= cfg_data[BYTE_W-1:0];
				REG_TAIL:     tail_q     <= cfg_data[BYTE_W-1:0];
				REG_NODE:     node_q     <= cfg_data[BYTE_W-1:0];
				REG_EXPECTED: expected_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_stall  = busy;
	assign in_accept = in_valid && !in_stall;

	fsp_rx_parser #(
		.DEPTH (FRAME_DEPTH),
		.AW    (AW)
	) u_parser (
		.clk          (clk),
		.arst_n       (arst_n),
		.accept       (in_accept),
		.rx_byte      (rx_byte),
		.header_byte  (header_q),
		.tail_byte    (tail_q),
		.node_address (node_q),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.frame_cmd    (frame_cmd)
	);

	fsp_frame_mem #(
		.DEPTH (FRAME_DEPTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	fsp_emitter #(
		.DEPTH (FRAME_DEPTH),
		.AW    (AW)
	) u_emitter (
		.clk             (clk),
		.arst_n          (arst_n),
		.frame_cmd       (frame_cmd),
		.expected_packet (expected_q),
		.busy            (busy),
		.mem_re          (mem_re),
		.mem_raddr       (mem_raddr),
		.mem_rdata       (mem_rdata),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.event_res       (event_res),
		.value           (value),
		.data_byte       (data_byte),
		.data_valid      (data_valid),
		.byte_index      (byte_index),
		.last            (last)
	);

endmodule

### rtl/core/fsp_checker.sv
// fsp_checker: port-level checks of the frame parser, bound to the top level
module fsp_checker
	import fsp_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input logic [EV_W-1:0]   event_res,
	input logic [WORD_W-1:0] value,
	input logic [BYTE_W-1:0] data_byte,
	input logic              data_valid,
	input logic [IDX_W-1:0]  byte_index,
	input logic              last
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_res) &&
		$stable(value) && $stable(data_byte) && $stable(byte_index) && $stable(last))
		else $error("stalled item changed");

	a_no_data_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !data_valid |-> (data_byte == '0) && (byte_index == '0) && last)
		else $error("non-data item carries payload fields or is not last");

	a_data_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && data_valid |-> (event_res == EV_DATA))
		else $error("payload byte on a non-data event");

	a_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((event_res == EV_LAUNCH) || (event_res == EV_JUMP)) |-> (value == '0))
		else $error("launch or jump with nonzero value");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && data_valid && !last ##1 out_valid |->
		data_valid && (byte_index == $past(byte_index) + IDX_W'(1)))
		else $error("payload index did not advance by one");

endmodule

bind serial_command_frame_parser_core fsp_checker u_fsp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.event_res  (event_res),
	.value      (value),
	.data_byte  (data_byte),
	.data_valid (data_valid),
	.byte_index (byte_index),
	.last       (last)
);
